FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros
// assertion macros shared by the rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define UDL_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define UDL_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

FILE: rtl/udl_pkg.sv
// ----------------------------------------------------------------------------
// udl_pkg
// types, constants and fixed-point helpers of the undistort lift pipeline
// ----------------------------------------------------------------------------
package udl_pkg;

   localparam int ITERATIONS = 8;
   localparam int ADDR_W     = 5;

   typedef enum logic [2:0] {
      REG_INV_FOCAL_X   = 3'd0,
      REG_OFFSET_X      = 3'd1,
      REG_INV_FOCAL_Y   = 3'd2,
      REG_OFFSET_Y      = 3'd3,
      REG_RADIAL_K1     = 3'd4,
      REG_RADIAL_K2     = 3'd5,
      REG_TANGENTIAL_P1 = 3'd6,
      REG_TANGENTIAL_P2 = 3'd7
   } reg_idx_type;

   typedef logic signed [31:0] q_type;
   typedef logic signed [23:0] out_type;

   typedef struct packed {
      logic [31:0] inv_focal_x;
      q_type       offset_x;
      logic [31:0] inv_focal_y;
      q_type       offset_y;
      q_type       radial_k1;
      q_type       radial_k2;
      q_type       tangential_p1;
      q_type       tangential_p2;
   } cfg_type;

   // current estimate and distorted point
   typedef struct packed {
      q_type x;
      q_type y;
      q_type xd;
      q_type yd;
   } point_type;

   function automatic q_type sat_q(input logic signed [65:0] v);
      if (v > 66'sd2147483647) begin
         return 32'sh7fffffff;
      end else if (v < -66'sd2147483648) begin
         return 32'sh80000000;
      end
      return v[31:0];
   endfunction

   // product rounded half up to q7.24, saturated
   function automatic q_type mulq(input q_type a, input q_type b);
      logic signed [63:0] p;
      logic signed [65:0] s;
      p = a * b;
      s = (66'(p) + 66'sd8388608) >>> 24;
      return sat_q(s);
   endfunction

   function automatic out_type to_out(input q_type v);
      logic signed [32:0] t;
      t = (33'(v) + 33'sd8) >>> 4;
      if (t > 33'sd8388607) begin
         return 24'sh7fffff;
      end else if (t < -33'sd8388608) begin
         return 24'sh800000;
      end
      return t[23:0];
   endfunction

endpackage

FILE: rtl/udl_ifs.sv
// ----------------------------------------------------------------------------
// udl_ifs
// request and response channels of the undistort lift
// ----------------------------------------------------------------------------
interface udl_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] pixel_u;
   logic [15:0] pixel_v;
   modport source (output valid, output pixel_u, output pixel_v, input ready);
   modport sink (input valid, input pixel_u, input pixel_v, output ready);
endinterface

interface udl_rsp_if;
   logic        valid;
   logic        ready;
   logic signed [23:0] norm_x;
   logic signed [23:0] norm_y;
   modport source (output valid, output norm_x, output norm_y, input ready);
   modport sink (input valid, input norm_x, input norm_y, output ready);
endinterface

FILE: rtl/udl_csr.sv
// ----------------------------------------------------------------------------
// udl_csr
// apb register file holding intrinsics and distortion coefficients
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module udl_csr (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_psel,
   input  logic                       csr_penable,
   input  logic                       csr_pwrite,
   input  logic [udl_pkg::ADDR_W-1:0] csr_paddr,
   input  logic [31:0]                csr_pwdata,
   output logic [31:0]                csr_prdata,
   output logic                       csr_pready,
   output udl_pkg::cfg_type           cfg
);

   udl_pkg::cfg_type    cfg_ff;
   udl_pkg::reg_idx_type idx;
   logic                wr;

   assign idx        = udl_pkg::reg_idx_type'(csr_paddr[4:2]);
   assign wr         = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (wr) begin
         case (idx)
            udl_pkg::REG_INV_FOCAL_X:   cfg_ff.inv_focal_x   <= csr_pwdata;
            udl_pkg::REG_OFFSET_X:      cfg_ff.offset_x      <= csr_pwdata;
            udl_pkg::REG_INV_FOCAL_Y:   cfg_ff.inv_focal_y   <= csr_pwdata;
            udl_pkg::REG_OFFSET_Y:      cfg_ff.offset_y      <= csr_pwdata;
            udl_pkg::REG_RADIAL_K1:     cfg_ff.radial_k1     <= csr_pwdata;
            udl_pkg::REG_RADIAL_K2:     cfg_ff.radial_k2     <= csr_pwdata;
            udl_pkg::REG_TANGENTIAL_P1: cfg_ff.tangential_p1 <= csr_pwdata;
            udl_pkg::REG_TANGENTIAL_P2: cfg_ff.tangential_p2 <= csr_pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (idx)
         udl_pkg::REG_INV_FOCAL_X:   csr_prdata = cfg_ff.inv_focal_x;
         udl_pkg::REG_OFFSET_X:      csr_prdata = cfg_ff.offset_x;
         udl_pkg::REG_INV_FOCAL_Y:   csr_prdata = cfg_ff.inv_focal_y;
         udl_pkg::REG_OFFSET_Y:      csr_prdata = cfg_ff.offset_y;
         udl_pkg::REG_RADIAL_K1:     csr_prdata = cfg_ff.radial_k1;
         udl_pkg::REG_RADIAL_K2:     csr_prdata = cfg_ff.radial_k2;
         udl_pkg::REG_TANGENTIAL_P1: csr_prdata = cfg_ff.tangential_p1;
         udl_pkg::REG_TANGENTIAL_P2: csr_prdata = cfg_ff.tangential_p2;
         default:                    csr_prdata = '0;
      endcase
   end

   `UDL_ASSERT_NEXT(a_k1_write, wr && idx == udl_pkg::REG_RADIAL_K1,
                    cfg_ff.radial_k1 == $past(csr_pwdata))
   `UDL_ASSERT_NEXT(a_no_write_hold, !wr, $stable(cfg_ff))

endmodule

FILE: rtl/udl_lift.sv
// ----------------------------------------------------------------------------
// udl_lift
// inverse intrinsics: pixel to distorted normalized point, two stages
// ----------------------------------------------------------------------------
module udl_lift (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  udl_pkg::cfg_type     cfg,
   input  logic                 in_valid,
   input  logic [15:0]          pixel_u,
   input  logic [15:0]          pixel_v,
   output logic                 out_valid,
   output udl_pkg::point_type   out_pt
);

   logic [1:0]         valid_ff;
   logic [47:0]        prod_x_ff;
   logic [47:0]        prod_y_ff;
   udl_pkg::point_type pt_ff;
   logic [36:0]        scaled_x;
   logic [36:0]        scaled_y;
   udl_pkg::q_type     xd;
   udl_pkg::q_type     yd;

   // round half up from 0.36 fraction to q.24
   assign scaled_x = 37'((49'(prod_x_ff) + 49'd2048) >> 12);
   assign scaled_y = 37'((49'(prod_y_ff) + 49'd2048) >> 12);
   assign xd = udl_pkg::sat_q(66'(signed'({1'b0, scaled_x})) + 66'(cfg.offset_x));
   assign yd = udl_pkg::sat_q(66'(signed'({1'b0, scaled_y})) + 66'(cfg.offset_y));

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_x_ff <= 48'(cfg.inv_focal_x) * 48'(pixel_u);
         prod_y_ff <= 48'(cfg.inv_focal_y) * 48'(pixel_v);
         pt_ff     <= '{x: xd, y: yd, xd: xd, yd: yd};
      end
   end

   assign out_valid = valid_ff[1];
   assign out_pt    = pt_ff;

endmodule

FILE: rtl/udl_iter.sv
// ----------------------------------------------------------------------------
// udl_iter
// one fixed-point undistortion iteration in six register stages
// ----------------------------------------------------------------------------
module udl_iter (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  udl_pkg::cfg_type     cfg,
   input  logic                 in_valid,
   input  udl_pkg::point_type   in_pt,
   output logic                 out_valid,
   output udl_pkg::point_type   out_pt
);

   logic [5:0] valid_ff;

   udl_pkg::point_type pt1_ff, pt2_ff, pt3_ff, pt4_ff, pt5_ff, pt6_ff;
   udl_pkg::q_type x2_1_ff, y2_1_ff, xy_1_ff;
   udl_pkg::q_type x2_2_ff, y2_2_ff, r_2_ff, ptx_2_ff, pty_2_ff;
   udl_pkg::q_type rr_3_ff, k1r_3_ff, sx_3_ff, sy_3_ff, tx_3_ff, ty_3_ff;
   udl_pkg::q_type rad_4_ff, sx_4_ff, sy_4_ff, tx_4_ff, ty_4_ff;
   udl_pkg::q_type mx_5_ff, my_5_ff, qx_5_ff, qy_5_ff, tx_5_ff, ty_5_ff;
   udl_pkg::q_type dx, dy;

   assign dx = udl_pkg::sat_q(66'(mx_5_ff) + 66'(tx_5_ff) + 66'(qx_5_ff));
   assign dy = udl_pkg::sat_q(66'(my_5_ff) + 66'(ty_5_ff) + 66'(qy_5_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[4:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         // squares and cross term
         pt1_ff  <= in_pt;
         x2_1_ff <= udl_pkg::mulq(in_pt.x, in_pt.x);
         y2_1_ff <= udl_pkg::mulq(in_pt.y, in_pt.y);
         xy_1_ff <= udl_pkg::mulq(in_pt.x, in_pt.y);
         // radius and tangential products
         pt2_ff   <= pt1_ff;
         x2_2_ff  <= x2_1_ff;
         y2_2_ff  <= y2_1_ff;
         r_2_ff   <= udl_pkg::sat_q(66'(x2_1_ff) + 66'(y2_1_ff));
         ptx_2_ff <= udl_pkg::mulq(cfg.tangential_p1, xy_1_ff);
         pty_2_ff <= udl_pkg::mulq(cfg.tangential_p2, xy_1_ff);
         // r squared, k1 term, tangential sums
         pt3_ff   <= pt2_ff;
         rr_3_ff  <= udl_pkg::mulq(r_2_ff, r_2_ff);
         k1r_3_ff <= udl_pkg::mulq(cfg.radial_k1, r_2_ff);
         sx_3_ff  <= udl_pkg::sat_q(66'(r_2_ff) + 66'(udl_pkg::sat_q(66'(x2_2_ff) + 66'(x2_2_ff))));
         sy_3_ff  <= udl_pkg::sat_q(66'(r_2_ff) + 66'(udl_pkg::sat_q(66'(y2_2_ff) + 66'(y2_2_ff))));
         tx_3_ff  <= udl_pkg::sat_q(66'(ptx_2_ff) + 66'(ptx_2_ff));
         ty_3_ff  <= udl_pkg::sat_q(66'(pty_2_ff) + 66'(pty_2_ff));
         // radial factor
         pt4_ff   <= pt3_ff;
         rad_4_ff <= udl_pkg::sat_q(66'(k1r_3_ff) + 66'(udl_pkg::mulq(cfg.radial_k2, rr_3_ff)));
         sx_4_ff  <= sx_3_ff;
         sy_4_ff  <= sy_3_ff;
         tx_4_ff  <= tx_3_ff;
         ty_4_ff  <= ty_3_ff;
         // final products
         pt5_ff  <= pt4_ff;
         mx_5_ff <= udl_pkg::mulq(pt4_ff.x, rad_4_ff);
         my_5_ff <= udl_pkg::mulq(pt4_ff.y, rad_4_ff);
         qx_5_ff <= udl_pkg::mulq(cfg.tangential_p2, sx_4_ff);
         qy_5_ff <= udl_pkg::mulq(cfg.tangential_p1, sy_4_ff);
         tx_5_ff <= tx_4_ff;
         ty_5_ff <= ty_4_ff;
         // new estimate
         pt6_ff.x  <= udl_pkg::sat_q(66'(pt5_ff.xd) - 66'(dx));
         pt6_ff.y  <= udl_pkg::sat_q(66'(pt5_ff.yd) - 66'(dy));
         pt6_ff.xd <= pt5_ff.xd;
         pt6_ff.yd <= pt5_ff.yd;
      end
   end

   assign out_valid = valid_ff[5];
   assign out_pt    = pt6_ff;

endmodule

FILE: rtl/pinhole_undistort_lift_top.sv
// ----------------------------------------------------------------------------
// pinhole_undistort_lift_top
// lifts subpixel image points to undistorted normalized camera coordinates
// ----------------------------------------------------------------------------
// Takes one point per clock unless the response stalls, and returns one
// result per point, in order, through two stages of inverse intrinsics, six
// stages per unrolled distortion iteration (each holding at most one 32x32
// multiply level), and the response register. A stalled response freezes
// the whole pipeline, so nothing is dropped or repeated; while the response
// is free the request side is always ready. With radial_k1 at zero the
// distorted point is returned as is. The user must write registers over apb
// only while no request is in flight; the block does not enforce this.
`include "assert_macros.svh"

module pinhole_undistort_lift_top (
   input  logic                       clock,
   input  logic                       reset,
   udl_req_if.sink                    req,
   udl_rsp_if.source                  rsp,
   input  logic                       csr_psel,
   input  logic                       csr_penable,
   input  logic                       csr_pwrite,
   input  logic [udl_pkg::ADDR_W-1:0] csr_paddr,
   input  logic [31:0]                csr_pwdata,
   output logic [31:0]                csr_prdata,
   output logic                       csr_pready
);

   localparam int N = udl_pkg::ITERATIONS;

   udl_pkg::cfg_type   cfg;
   logic               en;
   logic [N:0]         stage_valid;
   udl_pkg::point_type stage_pt [N+1];

   logic               rsp_valid_ff;
   udl_pkg::out_type   norm_x_ff;
   udl_pkg::out_type   norm_y_ff;
   udl_pkg::q_type     res_x;
   udl_pkg::q_type     res_y;

   // whole pipeline moves unless the response register is held
   assign en        = !rsp_valid_ff || rsp.ready;
   assign req.ready = en;

   udl_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // inverse intrinsics
   udl_lift u_lift (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .cfg       (cfg),
      .in_valid  (req.valid),
      .pixel_u   (req.pixel_u),
      .pixel_v   (req.pixel_v),
      .out_valid (stage_valid[0]),
      .out_pt    (stage_pt[0])
   );

   // unrolled iterations
   for (genvar i = 0; i < N; i++) begin : g_iter
      udl_iter u_iter (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .cfg       (cfg),
         .in_valid  (stage_valid[i]),
         .in_pt     (stage_pt[i]),
         .out_valid (stage_valid[i+1]),
         .out_pt    (stage_pt[i+1])
      );
   end

   // bypass when undistortion is off
   assign res_x = (cfg.radial_k1 == '0) ? stage_pt[N].xd : stage_pt[N].x;
   assign res_y = (cfg.radial_k1 == '0) ? stage_pt[N].yd : stage_pt[N].y;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= stage_valid[N];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         norm_x_ff <= udl_pkg::to_out(res_x);
         norm_y_ff <= udl_pkg::to_out(res_y);
      end
   end

   assign rsp.valid  = rsp_valid_ff;
   assign rsp.norm_x = norm_x_ff;
   assign rsp.norm_y = norm_y_ff;

   // a held response freezes the pipeline occupancy
   `UDL_ASSERT_NEXT(a_stall_freezes, rsp_valid_ff && !rsp.ready, $stable(stage_valid))
   // a finished point reaches the response register when it is free
   `UDL_ASSERT_NEXT(a_drain, !rsp_valid_ff && stage_valid[N], rsp_valid_ff)

endmodule
